// File: hdl/ppr_pkg.sv
package ppr_pkg;

	localparam int MagW   = 49;
	localparam int NormW  = 30;
	localparam int SqW    = 60;
	localparam int SumW   = 62;
	localparam int RootW  = 31;
	localparam int QuoW   = 15;
	localparam int RemW   = 47;
	localparam int DenW   = 32;
	localparam int CfgW   = 64;
	localparam int IdxW   = 3;

	typedef enum logic [IdxW-1:0] {
		REG_U_AXIS,
		REG_V_AXIS,
		REG_N_AXIS,
		REG_PLANE_CORNER,
		REG_PIXEL_SIZE,
		REG_NEAR_DISTANCE,
		REG_EYE_POINT
	} reg_idx_t;

	typedef struct packed {
		logic [47:0] u_axis;
		logic [47:0] v_axis;
		logic [47:0] n_axis;
		logic [63:0] plane_corner;
		logic [63:0] pixel_size;
		logic [30:0] near_distance;
	} cam_cfg_t;

	typedef struct packed {
		logic [2:0][NormW-1:0] mag;
		logic [2:0]            neg;
		logic                  zero;
	} norm_t;

	typedef struct packed {
		norm_t           nrm;
		logic [SumW-1:0] sum;
	} front_t;

	typedef struct packed {
		norm_t            nrm;
		logic [RootW-1:0] len;
	} root_t;

	typedef struct packed {
		logic [2:0][QuoW-1:0] quo;
		logic [2:0]           neg;
		logic                 zero;
	} quot_t;

endpackage

// File: hdl/ppr_front.sv
module ppr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  ppr_pkg::cam_cfg_t cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [23:0]       x_pos,
	input  logic [23:0]       y_pos,
	output logic              out_valid,
	input  logic              out_ready,
	output ppr_pkg::front_t   out_data
);

	localparam int NStg = 9;

	function automatic logic signed [31:0] plane_coord(input logic [31:0] edge_bits,
			input logic [55:0] prod);
		logic signed [57:0] s;
		logic signed [49:0] q;
		logic signed [57:0] e;
		logic signed [57:0] p;
		e = 58'(signed'(edge_bits));
		p = signed'({2'b00, prod});
		s = (e <<< 8) + p;
		q = 50'(s >>> 8);
		if (q > 50'sd2147483647) begin
			plane_coord = 32'sh7fffffff;
		end else if (q < -50'sd2147483648) begin
			plane_coord = 32'sh80000000;
		end else begin
			plane_coord = signed'(q[31:0]);
		end
	endfunction

	logic [NStg:1]   v;
	logic [NStg+1:1] rdy;

	logic [55:0] prod_u_s1, prod_v_s1;
	logic signed [31:0] pu_s2, pv_s2;
	logic signed [2:0][47:0] pa_s3, pb_s3, pc_s3;
	logic [2:0][ppr_pkg::MagW-1:0] mag_s4, mag_s5, mag_s6;
	logic [2:0] neg_s4, neg_s5, neg_s6, neg_s7, neg_s8, neg_s9;
	logic [ppr_pkg::MagW-1:0] mx_s5;
	logic [5:0] bl_s6;
	logic zero_s6, zero_s7, zero_s8, zero_s9;
	logic [2:0][ppr_pkg::NormW-1:0] nm_s7, nm_s8, nm_s9;
	logic [2:0][ppr_pkg::SqW-1:0] sq_s8;
	logic [ppr_pkg::SumW-1:0] sum_s9;

	logic signed [2:0][15:0] ua, va, na;
	logic signed [31:0] nr;
	logic signed [2:0][49:0] comp;
	logic [ppr_pkg::MagW-1:0] mx_c;
	logic [5:0] bl_c;
	logic [2:0][ppr_pkg::NormW-1:0] nm_c;

	assign rdy[NStg+1] = out_ready;
	for (genvar k = 1; k <= NStg; k++) begin : g_rdy
		assign rdy[k] = !v[k] || rdy[k+1];
	end
	assign in_ready = rdy[1];
	assign out_valid = v[NStg];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (rdy[1]) v[1] <= in_valid;
			for (int k = 2; k <= NStg; k++) begin
				if (rdy[k]) v[k] <= v[k-1];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ua[i] = signed'(cfg.u_axis[16*i +: 16]);
			va[i] = signed'(cfg.v_axis[16*i +: 16]);
			na[i] = signed'(cfg.n_axis[16*i +: 16]);
		end
		nr = signed'({1'b0, cfg.near_distance});
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			comp[i] = 50'(signed'(pa_s3[i])) + 50'(signed'(pb_s3[i]))
				- 50'(signed'(pc_s3[i]));
		end
	end

	always_comb begin
		mx_c = mag_s4[0];
		if (mag_s4[1] > mx_c) mx_c = mag_s4[1];
		if (mag_s4[2] > mx_c) mx_c = mag_s4[2];
	end

	always_comb begin
		bl_c = '0;
		for (int i = 0; i < ppr_pkg::MagW; i++) begin
			if (mx_s5[i]) bl_c = 6'(i + 1);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (bl_s6 > 6'(ppr_pkg::NormW)) begin
				nm_c[i] = ppr_pkg::NormW'(mag_s6[i] >> (bl_s6 - 6'(ppr_pkg::NormW)));
			end else begin
				nm_c[i] = ppr_pkg::NormW'(mag_s6[i] << (6'(ppr_pkg::NormW) - bl_s6));
			end
		end
	end

	// plane coordinates, direction components, normalization and sum of squares
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			prod_u_s1 <= 56'(x_pos) * 56'(cfg.pixel_size[31:0]);
			prod_v_s1 <= 56'(y_pos) * 56'(cfg.pixel_size[63:32]);
		end
		if (rdy[2]) begin
			pu_s2 <= plane_coord(cfg.plane_corner[31:0], prod_u_s1);
			pv_s2 <= plane_coord(cfg.plane_corner[63:32], prod_v_s1);
		end
		if (rdy[3]) begin
			for (int i = 0; i < 3; i++) begin
				pa_s3[i] <= 48'(signed'(ua[i])) * 48'(pu_s2);
				pb_s3[i] <= 48'(signed'(va[i])) * 48'(pv_s2);
				pc_s3[i] <= 48'(signed'(na[i])) * 48'(nr);
			end
		end
		if (rdy[4]) begin
			for (int i = 0; i < 3; i++) begin
				neg_s4[i] <= comp[i][49];
				mag_s4[i] <= comp[i][49] ? ppr_pkg::MagW'(-comp[i])
					: ppr_pkg::MagW'(comp[i]);
			end
		end
		if (rdy[5]) begin
			mag_s5 <= mag_s4;
			neg_s5 <= neg_s4;
			mx_s5  <= mx_c;
		end
		if (rdy[6]) begin
			mag_s6  <= mag_s5;
			neg_s6  <= neg_s5;
			bl_s6   <= bl_c;
			zero_s6 <= (mx_s5 == '0);
		end
		if (rdy[7]) begin
			nm_s7   <= nm_c;
			neg_s7  <= neg_s6;
			zero_s7 <= zero_s6;
		end
		if (rdy[8]) begin
			for (int i = 0; i < 3; i++) begin
				sq_s8[i] <= ppr_pkg::SqW'(nm_s7[i]) * ppr_pkg::SqW'(nm_s7[i]);
			end
			nm_s8   <= nm_s7;
			neg_s8  <= neg_s7;
			zero_s8 <= zero_s7;
		end
		if (rdy[9]) begin
			sum_s9  <= ppr_pkg::SumW'(sq_s8[0]) + ppr_pkg::SumW'(sq_s8[1])
				+ ppr_pkg::SumW'(sq_s8[2]);
			nm_s9   <= nm_s8;
			neg_s9  <= neg_s8;
			zero_s9 <= zero_s8;
		end
	end

	assign out_data.nrm.mag  = nm_s9;
	assign out_data.nrm.neg  = neg_s9;
	assign out_data.nrm.zero = zero_s9;
	assign out_data.sum      = sum_s9;

endmodule

// File: hdl/ppr_isqrt.sv
module ppr_isqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ppr_pkg::front_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output ppr_pkg::root_t   out_data
);

	localparam int NStg = ppr_pkg::RootW;
	localparam int W    = ppr_pkg::SumW;

	logic [NStg:1]   v;
	logic [NStg+1:1] rdy;

	logic [W-1:0]  rem_s [NStg+1];
	logic [W-1:0]  root_s [NStg+1];
	ppr_pkg::norm_t side_s [NStg+1];

	assign rem_s[0]  = in_data.sum;
	assign root_s[0] = '0;
	assign side_s[0] = in_data.nrm;

	assign rdy[NStg+1] = out_ready;
	for (genvar k = 1; k <= NStg; k++) begin : g_rdy
		assign rdy[k] = !v[k] || rdy[k+1];
	end
	assign in_ready  = rdy[1];
	assign out_valid = v[NStg];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (rdy[1]) v[1] <= in_valid;
			for (int k = 2; k <= NStg; k++) begin
				if (rdy[k]) v[k] <= v[k-1];
			end
		end
	end

	// one root bit per stage
	for (genvar k = 1; k <= NStg; k++) begin : g_stg
		localparam logic [W-1:0] Bit = W'(1) << (2 * (NStg - k));
		logic [W-1:0] trial;
		assign trial = root_s[k-1] + Bit;
		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				side_s[k] <= side_s[k-1];
				if (rem_s[k-1] >= trial) begin
					rem_s[k]  <= rem_s[k-1] - trial;
					root_s[k] <= (root_s[k-1] >> 1) + Bit;
				end else begin
					rem_s[k]  <= rem_s[k-1];
					root_s[k] <= root_s[k-1] >> 1;
				end
			end
		end
	end

	assign out_data.nrm = side_s[NStg];
	assign out_data.len = root_s[NStg][ppr_pkg::RootW-1:0];

endmodule

// File: hdl/ppr_div.sv
module ppr_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ppr_pkg::root_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output ppr_pkg::quot_t  out_data
);

	localparam int NStg = ppr_pkg::QuoW + 1;
	localparam int RW   = ppr_pkg::RemW;
	localparam int QW   = ppr_pkg::QuoW;

	logic [NStg:1]   v;
	logic [NStg+1:1] rdy;

	logic [2:0][RW-1:0] rem_s [NStg+1];
	logic [2:0][QW-1:0] quo_s [NStg+1];
	logic [ppr_pkg::DenW-1:0] den_s [NStg+1];
	logic [2:0] neg_s [NStg+1];
	logic       zero_s [NStg+1];

	assign rdy[NStg+1] = out_ready;
	for (genvar k = 1; k <= NStg; k++) begin : g_rdy
		assign rdy[k] = !v[k] || rdy[k+1];
	end
	assign in_ready  = rdy[1];
	assign out_valid = v[NStg];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (rdy[1]) v[1] <= in_valid;
			for (int k = 2; k <= NStg; k++) begin
				if (rdy[k]) v[k] <= v[k-1];
			end
		end
	end

	// numerator (mag << 15) + len, rounded against 2 * len
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			for (int i = 0; i < 3; i++) begin
				rem_s[1][i] <= (RW'(in_data.nrm.mag[i]) << QW) + RW'(in_data.len);
				quo_s[1][i] <= '0;
			end
			den_s[1]  <= {in_data.len, 1'b0};
			neg_s[1]  <= in_data.nrm.neg;
			zero_s[1] <= in_data.nrm.zero;
		end
	end

	// one quotient bit per stage, msb first
	for (genvar k = 2; k <= NStg; k++) begin : g_stg
		localparam int Sh = NStg - k;
		logic [RW-1:0] sub;
		assign sub = RW'(den_s[k-1]) << Sh;
		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				den_s[k]  <= den_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				zero_s[k] <= zero_s[k-1];
				for (int i = 0; i < 3; i++) begin
					if (rem_s[k-1][i] >= sub) begin
						rem_s[k][i] <= rem_s[k-1][i] - sub;
						quo_s[k][i] <= {quo_s[k-1][i][QW-2:0], 1'b1};
					end else begin
						rem_s[k][i] <= rem_s[k-1][i];
						quo_s[k][i] <= {quo_s[k-1][i][QW-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign out_data.quo  = quo_s[NStg];
	assign out_data.neg  = neg_s[NStg];
	assign out_data.zero = zero_s[NStg];

endmodule

// File: hdl/pinhole_primary_ray_generator.sv
// Pinhole primary ray generator: one request (sub-pixel x_pos, y_pos) in, one ray out, a
// new request every cycle unless stalled. Front stages form the plane coordinates, the
// direction components and their common normalizing shift, the root stages compute the
// integer square root one bit per stage, the divider divides the three components by
// the length one quotient bit per stage, and one output register holds the ray. A stall
// on the output only backs up requests once every stage holds a ray. The origin fields
// carry eye_point; camera registers must only be written while no request is in flight.
module pinhole_primary_ray_generator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ppr_pkg::IdxW-1:0]   cfg_index,
	input  logic [ppr_pkg::CfgW-1:0]   cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [23:0]                x_pos,
	input  logic [23:0]                y_pos,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [19:0]         origin_x,
	output logic signed [19:0]         origin_y,
	output logic signed [19:0]         origin_z,
	output logic signed [15:0]         dir_x,
	output logic signed [15:0]         dir_y,
	output logic signed [15:0]         dir_z,
	output logic                       degenerate
);

	ppr_pkg::cam_cfg_t cfg_q;
	logic [59:0] eye_q;

	logic front_ready, front_valid, root_ready, root_valid, div_ready, div_valid;
	logic out_ready;
	ppr_pkg::front_t front_data;
	ppr_pkg::root_t  root_data;
	ppr_pkg::quot_t  div_data;
	logic signed [2:0][15:0] dir_c;
	logic signed [2:0][15:0] dir_q;
	logic degenerate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.u_axis        <= '0;
			cfg_q.v_axis        <= '0;
			cfg_q.n_axis        <= '0;
			cfg_q.plane_corner  <= '0;
			cfg_q.pixel_size    <= '0;
			cfg_q.near_distance <= 31'd65536;
			eye_q               <= '0;
		end else if (cfg_we) begin
			case (ppr_pkg::reg_idx_t'(cfg_index))
				ppr_pkg::REG_U_AXIS:        cfg_q.u_axis        <= cfg_data[47:0];
				ppr_pkg::REG_V_AXIS:        cfg_q.v_axis        <= cfg_data[47:0];
				ppr_pkg::REG_N_AXIS:        cfg_q.n_axis        <= cfg_data[47:0];
				ppr_pkg::REG_PLANE_CORNER:  cfg_q.plane_corner  <= cfg_data;
				ppr_pkg::REG_PIXEL_SIZE:    cfg_q.pixel_size    <= cfg_data;
				ppr_pkg::REG_NEAR_DISTANCE: cfg_q.near_distance <= cfg_data[30:0];
				ppr_pkg::REG_EYE_POINT:     eye_q               <= cfg_data[59:0];
				default: ;
			endcase
		end
	end

	ppr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (front_ready),
		.x_pos     (x_pos),
		.y_pos     (y_pos),
		.out_valid (front_valid),
		.out_ready (root_ready),
		.out_data  (front_data)
	);

	ppr_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (root_ready),
		.in_data   (front_data),
		.out_valid (root_valid),
		.out_ready (div_ready),
		.out_data  (root_data)
	);

	ppr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (root_valid),
		.in_ready  (div_ready),
		.in_data   (root_data),
		.out_valid (div_valid),
		.out_ready (out_ready),
		.out_data  (div_data)
	);

	assign in_stall  = !front_ready;
	assign out_ready = !out_valid || !out_stall;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (div_data.zero) begin
				dir_c[i] = '0;
			end else if (div_data.neg[i]) begin
				dir_c[i] = -signed'({1'b0, div_data.quo[i]});
			end else begin
				dir_c[i] = signed'({1'b0, div_data.quo[i]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_ready) begin
			out_valid <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready) begin
			dir_q        <= dir_c;
			degenerate_q <= div_data.zero;
		end
	end

	assign origin_x   = signed'(eye_q[19:0]);
	assign origin_y   = signed'(eye_q[39:20]);
	assign origin_z   = signed'(eye_q[59:40]);
	assign dir_x      = dir_q[0];
	assign dir_y      = dir_q[1];
	assign dir_z      = dir_q[2];
	assign degenerate = degenerate_q;

`ifndef ASSERT_OFF
	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> dir_x == 16'sd0 && dir_y == 16'sd0 && dir_z == 16'sd0)
		else $error("degenerate ray with nonzero direction");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |->
			dir_x <= 16'sd16384 && dir_x >= -16'sd16384 &&
			dir_y <= 16'sd16384 && dir_y >= -16'sd16384 &&
			dir_z <= 16'sd16384 && dir_z >= -16'sd16384)
		else $error("direction component above unit length");

	a_unit_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |->
			dir_x >= 16'sd4096 || dir_x <= -16'sd4096 ||
			dir_y >= 16'sd4096 || dir_y <= -16'sd4096 ||
			dir_z >= 16'sd4096 || dir_z <= -16'sd4096)
		else $error("normalized direction far too short");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output moves");
`endif

endmodule
